// ===== hdl/assert_macros.svh =====
// shared assertion macros, clocked on the rising edge and off while reset is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CFC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cfc_pkg.sv =====
`default_nettype none

package cfc_pkg;

    localparam int MAX_TAPS = 4096;
    localparam int ADDR_W   = $clog2(MAX_TAPS);
    // wide enough to hold MAX_TAPS itself
    localparam int POS_W    = ADDR_W + 1;

    localparam int TC_W     = 13;
    localparam int IDX_W    = 12;
    localparam int TAP_W    = 18;
    localparam int SMP_W    = 16;
    localparam int OUT_W    = 24;
    localparam int PROD_W   = TAP_W + SMP_W;

    localparam int CMP_W    = (POS_W > TC_W) ? POS_W : TC_W;
    // keep a few guard bits above the output width for rounding and clamping
    localparam int ACC_W    = ((PROD_W + ADDR_W) > (OUT_W + 15)) ?
                              (PROD_W + ADDR_W) : (OUT_W + 15);
    // rounded sum and its value with the low 15 fraction bits dropped
    localparam int RS_W     = ACC_W + 1;
    localparam int Q_W      = RS_W - 15;

    // slave tdata: tap_index, tap_value, sample, then zero fill
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    localparam int IDX_LSB = 0;
    localparam int TAP_LSB = IDX_LSB + IDX_W;
    localparam int SMP_LSB = TAP_LSB + TAP_W;

    localparam int USR_ACTION = 0;
    localparam int USR_FIRST  = 1;

    localparam logic ACT_TAP    = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/causal_fir_convolution_core.sv =====
// channel   dir  tdata                                    tuser
// s (in)    in   tap_index, tap_value, sample, zero fill  action, first_of_clip
// m (out)   out  filtered_sample                          saturated
// cfg       in   tap_count (i_cfg_data, no address)       -
//
// a tap write beat starts no sum; a sample beat sums min(K, n+1) products,
// taken by the single multiply-accumulate walking the taps one per cycle
// the input is not ready while a sample is being summed
// a finished result sits in the output register, so a new beat is taken while it stalls
// synchronous active-low reset; no memory clearing pass is needed after reset
`default_nettype none

module causal_fir_convolution_core
    import cfc_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,

    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire  [TC_W-1:0]      i_cfg_data,

    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    input  wire  [S_TDATA_W-1:0] i_s_tdata,  // tap_index, tap_value, sample, zero fill
    input  wire  [S_TUSER_W-1:0] i_s_tuser,  // action, first_of_clip

    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    output logic [M_TDATA_W-1:0] o_m_tdata,  // filtered_sample
    output logic [M_TUSER_W-1:0] o_m_tuser   // saturated
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_ROUND
    } t_state;

    t_state r_state;
    logic [TC_W-1:0]    r_tap_count;
    logic [ADDR_W-1:0]  r_wp;
    logic [POS_W-1:0]   r_clip_pos;
    logic [ADDR_W-1:0]  r_k;
    logic [ADDR_W-1:0]  r_idx;
    logic [ADDR_W-1:0]  r_khi;
    logic               r_rd_vld;
    logic               r_rd_last;
    logic               r_p_vld;
    logic               r_p_last;
    logic               r_out_vld;
    logic [OUT_W-1:0]   r_out_data;
    logic               r_out_sat;

    logic signed [TAP_W-1:0]  r_tap_mem [MAX_TAPS];
    logic signed [SMP_W-1:0]  r_hist_mem [MAX_TAPS];
    logic signed [TAP_W-1:0]  r_tap_q;
    logic signed [SMP_W-1:0]  r_hist_q;
    logic signed [PROD_W-1:0] r_p;
    logic signed [ACC_W-1:0]  r_acc;

    logic               w_accept;
    logic               w_action;
    logic               w_first;
    logic [IDX_W-1:0]   w_tap_index;
    logic [TAP_W-1:0]   w_tap_value;
    logic [SMP_W-1:0]   w_sample;
    logic               w_tap_we;
    logic               w_smp_go;
    logic [CMP_W-1:0]   w_tc;
    logic [CMP_W-1:0]   w_kcnt;
    logic [POS_W-1:0]   w_pos;
    logic [CMP_W-1:0]   w_khi;
    logic [POS_W-1:0]   n_clip_pos;
    logic [ADDR_W-1:0]  n_wp;
    logic [ADDR_W-1:0]  n_idx;
    logic               w_last_issue;
    logic               w_out_free;
    logic signed [RS_W-1:0] w_rsum;
    logic signed [Q_W-1:0]  w_q;
    logic               w_fits;
    logic [OUT_W-1:0]   w_rnd;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_out_vld;
    assign o_m_tdata   = r_out_data;
    assign o_m_tuser   = r_out_sat;

    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_action    = i_s_tuser[USR_ACTION];
    assign w_first     = i_s_tuser[USR_FIRST];
    assign w_tap_index = i_s_tdata[IDX_LSB +: IDX_W];
    assign w_tap_value = i_s_tdata[TAP_LSB +: TAP_W];
    assign w_sample    = i_s_tdata[SMP_LSB +: SMP_W];

    assign w_tap_we = w_accept && (w_action == ACT_TAP) &&
                      (CMP_W'(w_tap_index) < CMP_W'(MAX_TAPS));
    assign w_smp_go = w_accept && (w_action == ACT_SAMPLE);

    always_comb begin
        w_tc = CMP_W'(r_tap_count);
        if (w_tc == '0) begin
            w_kcnt = CMP_W'(1);
        end else if (w_tc > CMP_W'(MAX_TAPS)) begin
            w_kcnt = CMP_W'(MAX_TAPS);
        end else begin
            w_kcnt = w_tc;
        end
        w_pos = w_first ? '0 : r_clip_pos;
        // the sum stops at the clip start or at the last tap, whichever is nearer
        w_khi = (CMP_W'(w_pos) < (w_kcnt - CMP_W'(1))) ? CMP_W'(w_pos)
                                                        : (w_kcnt - CMP_W'(1));
        n_clip_pos = (w_pos >= POS_W'(MAX_TAPS)) ? POS_W'(MAX_TAPS)
                                                 : (w_pos + POS_W'(1));
        n_wp  = (r_wp == ADDR_W'(MAX_TAPS - 1)) ? '0 : (r_wp + ADDR_W'(1));
        n_idx = (r_idx == '0) ? ADDR_W'(MAX_TAPS - 1) : (r_idx - ADDR_W'(1));
    end

    assign w_last_issue = (r_state == S_RUN) && (r_k == r_khi);
    assign w_out_free   = !r_out_vld || i_m_tready;

    // round half up from 30 to 15 fraction bits, then clamp to 24 bits
    always_comb begin
        w_rsum = RS_W'(r_acc) + RS_W'(1 << 14);
        w_q    = Q_W'(w_rsum >>> 15);
        w_fits = (w_q[Q_W-1:OUT_W-1] == '0) || (w_q[Q_W-1:OUT_W-1] == '1);
        if (w_fits) begin
            w_rnd = w_q[OUT_W-1:0];
        end else if (w_q[Q_W-1]) begin
            w_rnd = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            w_rnd = {1'b0, {(OUT_W-1){1'b1}}};
        end
    end

    // history entries are only read back within the current fill count,
    // so an entry is always written before it is read and needs no clearing
    always_ff @(posedge i_clk) begin
        if (w_tap_we) begin
            r_tap_mem[ADDR_W'(w_tap_index)] <= w_tap_value;
        end
        if (w_smp_go) begin
            r_hist_mem[r_wp] <= w_sample;
        end
        r_tap_q  <= r_tap_mem[r_k];
        r_hist_q <= r_hist_mem[r_idx];
    end

    // shared multiply-accumulate datapath
    always_ff @(posedge i_clk) begin
        r_p <= r_tap_q * r_hist_q;
        if (w_smp_go) begin
            r_acc <= '0;
        end else if (r_p_vld) begin
            r_acc <= r_acc + ACC_W'(r_p);
        end
        if (w_smp_go) begin
            r_k   <= '0;
            r_idx <= r_wp;
            r_khi <= w_khi[ADDR_W-1:0];
        end else if (r_state == S_RUN) begin
            r_k   <= r_k + ADDR_W'(1);
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap_count <= TC_W'(1);
            r_wp        <= '0;
            r_clip_pos  <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_p_vld     <= 1'b0;
            r_p_last    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_tap_count <= i_cfg_data;
            end
            r_rd_vld  <= (r_state == S_RUN);
            r_rd_last <= w_last_issue;
            r_p_vld   <= r_rd_vld;
            r_p_last  <= r_rd_vld && r_rd_last;
            if ((r_state == S_ROUND) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_smp_go) begin
                        r_wp       <= n_wp;
                        r_clip_pos <= n_clip_pos;
                        r_state    <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_last_issue) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    // last product lands in the accumulator on this edge
                    if (r_p_vld && r_p_last) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    if (w_out_free) begin
                        r_out_data <= w_rnd;
                        r_out_sat  <= !w_fits;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cfc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module cfc_checker
    import cfc_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 i_s_tvalid,
    input wire                 o_s_tready,
    input wire [S_TUSER_W-1:0] i_s_tuser,
    input wire                 o_m_tvalid,
    input wire                 i_m_tready,
    input wire [M_TDATA_W-1:0] o_m_tdata,
    input wire [M_TUSER_W-1:0] o_m_tuser
);

    logic w_s_beat;
    logic w_tap_beat;
    logic w_smp_beat;

    assign w_s_beat   = i_s_tvalid && o_s_tready;
    assign w_tap_beat = w_s_beat && (i_s_tuser[USR_ACTION] == ACT_TAP);
    assign w_smp_beat = w_s_beat && (i_s_tuser[USR_ACTION] == ACT_SAMPLE);

    `CFC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_m_tvalid && !i_m_tready, o_m_tvalid,
        "output beat dropped while stalled")
    `CFC_ASSERT_NEXT(a_tap_no_out, i_clk, i_rst_n,
        w_tap_beat && !o_m_tvalid, !o_m_tvalid,
        "tap write produced an output beat")
    `CFC_ASSERT_NEXT(a_smp_busy, i_clk, i_rst_n,
        w_smp_beat, !o_s_tready,
        "input ready while a sample is summed")
    `CFC_ASSERT_NOW(a_sat_clamp, i_clk, i_rst_n,
        o_m_tvalid && o_m_tuser[0],
        (o_m_tdata == 24'h7FFFFF) || (o_m_tdata == 24'h800000),
        "saturated flag without a clamped value")

endmodule

bind causal_fir_convolution_core cfc_checker u_cfc_checker (.*);

`default_nettype wire
